// File: sv/wbhc_pkg.sv
package wbhc_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int CFG_W              = 16;
   localparam int CSR_INDEX_W        = 3;
   localparam int TARGET_W           = 7;
   localparam int HYST_W             = 8;
   localparam int SENSOR_W           = 12;
   localparam int TEMP_W             = 11;
   localparam int PHASE_W            = 2;
   localparam int BAND_W             = 13;

   localparam int TEMP_LIMIT         = 1100;
   localparam int TEMP_SCALE         = 10;
   localparam int PUMP_OFFSET        = 10;
   localparam int HALF_SHIFT         = 1;
   localparam int QUARTER_SHIFT      = 2;

   localparam logic [TARGET_W-1:0] TARGET_RESET     = TARGET_W'(60);
   localparam logic [HYST_W-1:0]   HYST_RESET       = HYST_W'(5);
   localparam logic [CFG_W-1:0]    CYCLE_RESET      = CFG_W'(60);
   localparam logic [CFG_W-1:0]    PREHEAT_RESET    = CFG_W'(30);
   localparam logic [CFG_W-1:0]    COOK_RESET       = CFG_W'(40);
   localparam logic [CFG_W-1:0]    PUMP_START_RESET = CFG_W'(0);
   localparam logic [CFG_W-1:0]    PUMP_END_RESET   = CFG_W'(5);
   localparam logic [CFG_W-1:0]    READ_RESET       = CFG_W'(2);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_DEGREES    = 3'd0,
      CSR_HYSTERESIS_TENTHS = 3'd1,
      CSR_CYCLE_LIMIT       = 3'd2,
      CSR_PREHEAT_ON_LIMIT  = 3'd3,
      CSR_COOKING_PERIOD    = 3'd4,
      CSR_PUMP_WINDOW_START = 3'd5,
      CSR_PUMP_WINDOW_END   = 3'd6,
      CSR_READ_INTERVAL     = 3'd7
   } csr_index_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_CODE_INIT    = 2'd0,
      PHASE_CODE_PREHEAT = 2'd1,
      PHASE_CODE_COOKING = 2'd2
   } phase_code_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target_degrees;
      logic [HYST_W-1:0]   hysteresis_tenths;
      logic [CFG_W-1:0]    cycle_limit;
      logic [CFG_W-1:0]    preheat_on_limit;
      logic [CFG_W-1:0]    cooking_period;
      logic [CFG_W-1:0]    pump_window_start;
      logic [CFG_W-1:0]    pump_window_end;
      logic [CFG_W-1:0]    read_interval;
   } cfg_type;

   typedef struct packed {
      logic                       run_enable;
      logic signed [SENSOR_W-1:0] sensor_tenths;
   } req_type;

   typedef struct packed {
      logic               heater_on;
      logic               pump_on;
      logic [PHASE_W-1:0] phase;
      logic [TEMP_W-1:0]  held_temperature;
      logic               sample_taken;
   } rsp_type;

endpackage

// File: sv/water_bath_heater_controller.sv
// water bath heater controller
//
// req channel: one beat per one-second tick, carrying run_enable and the
// signed sensor reading in tenths of a degree. rsp channel: one beat per
// req beat, in order, with heater and pump drives, phase, held
// temperature and the sample flag.
// csr port: plain write port, to be written only while the block is idle;
// the block itself does not enforce this.
// a req beat is registered in the input register, then processed by the
// core into the rsp register, from which its rsp beat is valid; a low
// rsp_ready can hold it in the input register. throughput: one beat per
// cycle while rsp_ready does not stall; the controller state registers
// take their next state as each beat is processed.
//
// reset clears the pipeline, puts the phase in init, zeroes the timers,
// held temperature and drives, and loads the register defaults.
// when rsp_ready is low the rsp beat holds; a req beat is taken only into
// an empty input register, then req_ready drops until the rsp beat is taken.
module water_bath_heater_controller
   import wbhc_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data
);

   cfg_type cfg;
   req_type item_ff;
   logic    item_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   rsp_type result;
   logic    advance;

   wbhc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   wbhc_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/wbhc_csr.sv
module wbhc_csr
   import wbhc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_DEGREES:    cfg_in.target_degrees    = csr_write_data[TARGET_W-1:0];
            CSR_HYSTERESIS_TENTHS: cfg_in.hysteresis_tenths = csr_write_data[HYST_W-1:0];
            CSR_CYCLE_LIMIT:       cfg_in.cycle_limit       = csr_write_data;
            CSR_PREHEAT_ON_LIMIT:  cfg_in.preheat_on_limit  = csr_write_data;
            CSR_COOKING_PERIOD:    cfg_in.cooking_period    = csr_write_data;
            CSR_PUMP_WINDOW_START: cfg_in.pump_window_start = csr_write_data;
            CSR_PUMP_WINDOW_END:   cfg_in.pump_window_end   = csr_write_data;
            CSR_READ_INTERVAL:     cfg_in.read_interval     = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_degrees    <= TARGET_RESET;
         cfg_ff.hysteresis_tenths <= HYST_RESET;
         cfg_ff.cycle_limit       <= CYCLE_RESET;
         cfg_ff.preheat_on_limit  <= PREHEAT_RESET;
         cfg_ff.cooking_period    <= COOK_RESET;
         cfg_ff.pump_window_start <= PUMP_START_RESET;
         cfg_ff.pump_window_end   <= PUMP_END_RESET;
         cfg_ff.read_interval     <= READ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/wbhc_core.sv
module wbhc_core
   import wbhc_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
   localparam int SUM_W = CMP_W + 1;

   typedef enum logic [2:0] {
      PHASE_INIT    = 3'b001,
      PHASE_PREHEAT = 3'b010,
      PHASE_COOKING = 3'b100
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [TIMER_BITS-1:0]   cycle_ff, cycle_in;
   logic [TIMER_BITS-1:0]   duty_ff, duty_in;
   logic [TIMER_BITS-1:0]   read_ff, read_in;
   logic [TEMP_W-1:0]       temp_ff, temp_in;
   logic                    heater_ff, heater_in;
   logic                    pump_ff, pump_in;

   logic [TIMER_BITS-1:0]   cycle_next;
   logic [SUM_W-1:0]        cyc_s, start_s, end_s, start2_s, end2_s;
   logic                    pump_window;
   logic                    sampled;
   logic                    reading_ok;
   logic [TEMP_W-1:0]       temp_next;
   logic [CMP_W-1:0]        period_wide;
   logic [TIMER_BITS-1:0]   period;
   logic [TIMER_BITS-1:0]   duty_step;
   logic [TIMER_BITS-1:0]   duty_thresh;
   logic signed [BAND_W-1:0] temp_s, target_s, low_s, high_s;
   logic                    in_low, in_high;
   logic [PHASE_W-1:0]      phase_code;

   assign cycle_next = (CMP_W'(cfg.cycle_limit) > CMP_W'(cycle_ff))
                       ? cycle_ff + TIMER_BITS'(1) : '0;

   assign cyc_s    = SUM_W'(cycle_next);
   assign start_s  = SUM_W'(cfg.pump_window_start);
   assign end_s    = SUM_W'(cfg.pump_window_end);
   assign start2_s = start_s + SUM_W'(PUMP_OFFSET);
   assign end2_s   = end_s + SUM_W'(PUMP_OFFSET);
   assign pump_window = (cyc_s >= start_s && cyc_s < end_s) ||
                        (cyc_s >= start2_s && cyc_s < end2_s);

   assign sampled    = CMP_W'(read_ff) >= CMP_W'(cfg.read_interval);
   assign reading_ok = !item.sensor_tenths[SENSOR_W-1] &&
                       (item.sensor_tenths < SENSOR_W'(TEMP_LIMIT));
   assign temp_next  = (sampled && reading_ok) ? item.sensor_tenths[TEMP_W-1:0] : temp_ff;

   assign temp_s   = signed'(BAND_W'(temp_next));
   assign target_s = signed'(BAND_W'(cfg.target_degrees) * BAND_W'(TEMP_SCALE));
   assign low_s    = target_s - signed'(BAND_W'(cfg.hysteresis_tenths));
   assign high_s   = target_s + signed'(BAND_W'(cfg.hysteresis_tenths));
   assign in_low   = low_s >= temp_s;
   assign in_high  = high_s <= temp_s;

   // duty timer counts up to the period then restarts, on while below the fraction
   assign period_wide = CMP_W'(cfg.cooking_period);
   assign period      = period_wide[TIMER_BITS-1:0];
   assign duty_step   = (period > duty_ff) ? duty_ff + TIMER_BITS'(1) : period;
   assign duty_thresh = in_low ? (period >> HALF_SHIFT) : (period >> QUARTER_SHIFT);

   always_comb begin
      phase_in  = phase_ff;
      cycle_in  = cycle_ff;
      duty_in   = duty_ff;
      read_in   = read_ff;
      temp_in   = temp_ff;
      heater_in = heater_ff;
      pump_in   = pump_ff;
      if (!item.run_enable) begin
         phase_in = PHASE_INIT;
      end else begin
         cycle_in = cycle_next;
         pump_in  = pump_window;
         read_in  = sampled ? '0 : read_ff + TIMER_BITS'(1);
         temp_in  = temp_next;
         unique case (phase_ff)
            PHASE_INIT: begin
               heater_in = 1'b0;
               pump_in   = 1'b0;
               phase_in  = PHASE_PREHEAT;
            end
            PHASE_PREHEAT: begin
               if (target_s <= temp_s) begin
                  phase_in  = PHASE_COOKING;
                  heater_in = 1'b0;
               end else begin
                  heater_in = CMP_W'(cycle_next) <= CMP_W'(cfg.preheat_on_limit);
               end
            end
            PHASE_COOKING: begin
               if (!in_low && in_high) begin
                  heater_in = 1'b0;
                  duty_in   = '0;
               end else if (duty_thresh > duty_step) begin
                  heater_in = 1'b1;
                  duty_in   = duty_step;
               end else begin
                  heater_in = 1'b0;
                  duty_in   = (duty_step == period) ? '0 : duty_step;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_INIT;
         cycle_ff  <= '0;
         duty_ff   <= '0;
         read_ff   <= '0;
         temp_ff   <= '0;
         heater_ff <= 1'b0;
         pump_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         cycle_ff  <= cycle_in;
         duty_ff   <= duty_in;
         read_ff   <= read_in;
         temp_ff   <= temp_in;
         heater_ff <= heater_in;
         pump_ff   <= pump_in;
      end
   end

   always_comb begin
      unique case (phase_in)
         PHASE_INIT:    phase_code = PHASE_CODE_INIT;
         PHASE_PREHEAT: phase_code = PHASE_CODE_PREHEAT;
         PHASE_COOKING: phase_code = PHASE_CODE_COOKING;
         default:       phase_code = PHASE_CODE_INIT;
      endcase
   end

   assign result.heater_on        = heater_in;
   assign result.pump_on          = pump_in;
   assign result.phase            = phase_code;
   assign result.held_temperature = temp_in;
   assign result.sample_taken     = item.run_enable & sampled;

endmodule
